// ----- src/rwcst_pkg.sv -----
`default_nettype none

package rwcst_pkg;

  // widest slot index the table supports
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned SEQ_W   = 63;
  localparam int unsigned MAX_RES = 32;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_ACK   = 3'd1,
    OP_REQ   = 3'd2,
    OP_QUERY = 3'd3,
    OP_NEXT  = 3'd4,
    OP_LIST  = 3'd5
  } op_e;

  localparam logic [1:0] ST_UNSENT    = 2'd0;
  localparam logic [1:0] ST_UNACKED   = 2'd1;
  localparam logic [1:0] ST_REQUESTED = 2'd2;
  localparam logic [1:0] ST_ACKED     = 2'd3;

  localparam logic [2:0] OC_OK        = 3'd0;
  localparam logic [2:0] OC_REPLACED  = 3'd1;
  localparam logic [2:0] OC_COLLISION = 3'd2;
  localparam logic [2:0] OC_BASE_MISS = 3'd3;
  localparam logic [2:0] OC_NONE      = 3'd4;

  typedef struct packed {
    logic [2:0]       operation;
    logic [SEQ_W-1:0] seq_number;
    logic [1:0]       entry_status_in;
    logic             relevant_in;
    logic [31:0]      request_bitmap;
    logic [5:0]       bitmap_length;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       outcome;
    logic             found;
    logic [SEQ_W-1:0] seq_out;
    logic [5:0]       missing_count;
    logic             last_result;
  } rsp_t;

  // classified operation handed from front to back
  typedef struct packed {
    op_e               op;
    logic [SEQ_W-1:0]  seq;
    logic [1:0]        status;
    logic              rel;
    logic [31:0]       bmp;
    logic [5:0]        len;
    logic [SLOT_W-1:0] slot;
  } work_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [1:0]       status;
    logic             rel;
  } slot_t;

endpackage

`default_nettype wire

// ----- src/rwcst_front.sv -----
`default_nettype none

module rwcst_front #(
  parameter int unsigned WINDOW      = 32,
  parameter int unsigned BITMAP_BITS = 32
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  rwcst_pkg::cmd_t      cmd_i,
  output logic                 push_o,
  output rwcst_pkg::work_t     work_o,
  input  wire logic            full_i
);
  import rwcst_pkg::*;

  localparam int unsigned IDX_W   = $clog2(WINDOW);
  localparam bit          IS_POW2 = ((WINDOW & (WINDOW - 1)) == 0);
  localparam int unsigned LEN_MAX = (BITMAP_BITS < 32) ? BITMAP_BITS : 32;
  localparam logic [IDX_W:0] WIN_C = (IDX_W+1)'(WINDOW);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MOD  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e          state_q, state_d;
  work_t            work_q, work_d;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [3:0]       chunk_q, chunk_d;
  logic [IDX_W:0]   rem_t;
  logic [63:0]      seq_pad;
  logic [3:0]       chunk_bits;

  assign busy       = (state_q != F_IDLE);
  assign work_o     = work_q;
  assign seq_pad    = {1'b0, work_q.seq};
  assign chunk_bits = seq_pad[{chunk_q, 2'b00} +: 4];

  always_comb begin
    state_d = state_q;
    work_d  = work_q;
    rem_d   = rem_q;
    chunk_d = chunk_q;
    push_o  = 1'b0;
    rem_t   = '0;
    case (state_q)
      F_IDLE: begin
        if (start && (cmd_i.operation <= OP_LIST)) begin
          work_d.op     = op_e'(cmd_i.operation);
          work_d.seq    = cmd_i.seq_number;
          work_d.status = cmd_i.entry_status_in;
          work_d.rel    = cmd_i.relevant_in;
          work_d.bmp    = cmd_i.request_bitmap;
          work_d.len    = (cmd_i.bitmap_length > 6'(LEN_MAX)) ? 6'(LEN_MAX)
                                                               : cmd_i.bitmap_length;
          rem_d         = '0;
          chunk_d       = 4'd15;
          if (IS_POW2) begin
            work_d.slot = SLOT_W'(cmd_i.seq_number[IDX_W-1:0]);
            state_d     = F_PUSH;
          end else begin
            work_d.slot = '0;
            state_d     = F_MOD;
          end
        end
      end
      F_MOD: begin
        // four remainder steps per cycle, top bits first
        rem_t = {1'b0, rem_q};
        for (int b = 3; b >= 0; b--) begin
          rem_t = {rem_t[IDX_W-1:0], chunk_bits[b]};
          if (rem_t >= WIN_C) begin
            rem_t = rem_t - WIN_C;
          end
        end
        rem_d = rem_t[IDX_W-1:0];
        if (chunk_q == 4'd0) begin
          work_d.slot = SLOT_W'(rem_d);
          state_d     = F_PUSH;
        end else begin
          chunk_d = chunk_q - 4'd1;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    rem_q   <= rem_d;
    chunk_q <= chunk_d;
  end

endmodule

`default_nettype wire

// ----- src/rwcst_queue.sv -----
`default_nettype none

module rwcst_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  rwcst_pkg::work_t data_i,
  output logic             full_o,
  input  wire logic        pop_i,
  output rwcst_pkg::work_t data_o,
  output logic             empty_o
);
  import rwcst_pkg::*;

  work_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/rwcst_back.sv -----
`default_nettype none

module rwcst_back #(
  parameter int unsigned WINDOW      = 32,
  parameter int unsigned BITMAP_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        empty_i,
  input  rwcst_pkg::work_t work_i,
  output logic             pop_o,
  output logic             rsp_valid_o,
  output rwcst_pkg::rsp_t  rsp_o
);
  import rwcst_pkg::*;

  localparam int unsigned IDX_W   = $clog2(WINDOW);
  localparam int unsigned LEN_MAX = (BITMAP_BITS < 32) ? BITMAP_BITS : 32;
  localparam int unsigned CNT_W   = ($clog2(WINDOW + 1) > 6) ? $clog2(WINDOW + 1) : 6;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_FLUSH = 3'b100
  } bstate_e;

  bstate_e            state_q, state_d;
  work_t              cur_q, cur_d;
  logic [CNT_W-1:0]   iss_q, iss_d, total_q, total_d;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic [SEQ_W-1:0]   key_q, key_d, key_inc;
  logic [LEN_MAX-1:0] bmp_q, bmp_d;

  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [SEQ_W-1:0]   rd_key_q, rd_key_d;
  logic               rd_base_q, rd_base_d, rd_use_q, rd_use_d, rd_last_q, rd_last_d;

  slot_t              mem [WINDOW];
  slot_t              mem_q, byp_data_q, rdat, wdata;
  logic               byp_q, we;
  logic [IDX_W-1:0]   raddr;
  logic [WINDOW-1:0]  valid_q, valid_d;

  logic               base_hit_q, base_hit_d, base_hit_f;
  logic [5:0]         miss_q, miss_d, nres_q, nres_d;
  logic               best_vld_q, best_vld_d, have_q, have_d;
  logic [SEQ_W-1:0]   best_q, best_d, prev_q, prev_d;

  logic               rsp_valid_q, rsp_valid_d;
  rsp_t               rsp_q, rsp_d;

  logic               issue, vld, hit, cand;

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  assign issue   = (state_q == S_RUN) && (iss_q < total_q);
  assign key_inc = key_q + SEQ_W'(1);
  assign rdat    = byp_q ? byp_data_q : mem_q;
  assign vld     = valid_q[rd_idx_q];
  assign hit     = vld && (rdat.seq == rd_key_q);
  assign cand    = vld && (rdat.status == cur_q.status) && (!have_q || (rdat.seq > prev_q));

  always_comb begin
    case (cur_q.op)
      OP_ADD, OP_QUERY: raddr = cur_q.slot[IDX_W-1:0];
      OP_REQ:           raddr = addr_q;
      default:          raddr = iss_q[IDX_W-1:0];
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    iss_d       = iss_q;
    total_d     = total_q;
    addr_d      = addr_q;
    key_d       = key_q;
    bmp_d       = bmp_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    rd_key_d    = rd_key_q;
    rd_base_d   = rd_base_q;
    rd_use_d    = rd_use_q;
    rd_last_d   = rd_last_q;
    we          = 1'b0;
    wdata       = rdat;
    valid_d     = valid_q;
    base_hit_d  = base_hit_q;
    base_hit_f  = base_hit_q;
    miss_d      = miss_q;
    nres_d      = nres_q;
    best_vld_d  = best_vld_q;
    best_d      = best_q;
    have_d      = have_q;
    prev_d      = prev_q;
    rsp_valid_d = 1'b0;
    rsp_d       = '0;
    pop_o       = 1'b0;

    // dispatch
    if ((state_q == S_IDLE) && !empty_i) begin
      pop_o      = 1'b1;
      cur_d      = work_i;
      iss_d      = '0;
      addr_d     = work_i.slot[IDX_W-1:0];
      key_d      = work_i.seq;
      bmp_d      = work_i.bmp[LEN_MAX-1:0];
      base_hit_d = 1'b0;
      miss_d     = '0;
      best_vld_d = 1'b0;
      have_d     = 1'b0;
      nres_d     = '0;
      state_d    = S_RUN;
      case (work_i.op)
        OP_ADD, OP_QUERY: total_d = CNT_W'(1);
        OP_REQ:           total_d = CNT_W'(work_i.len) + CNT_W'(1);
        default:          total_d = CNT_W'(WINDOW);
      endcase
    end

    // read issue
    if (issue) begin
      iss_d     = iss_q + CNT_W'(1);
      rd_vld_d  = 1'b1;
      rd_idx_d  = raddr;
      rd_key_d  = (cur_q.op == OP_REQ) ? key_q : cur_q.seq;
      rd_base_d = (iss_q == '0);
      rd_use_d  = (iss_q != '0) && bmp_q[0];
      rd_last_d = (iss_q == total_q - CNT_W'(1));
      if ((cur_q.op == OP_REQ) && (iss_q != '0)) begin
        bmp_d = bmp_q >> 1;
        key_d = key_inc;
        if (key_inc == '0) begin
          addr_d = '0;
        end else if (addr_q == IDX_W'(WINDOW - 1)) begin
          addr_d = '0;
        end else begin
          addr_d = addr_q + IDX_W'(1);
        end
      end
    end

    // process registered read
    if (rd_vld_q) begin
      case (cur_q.op)
        OP_ADD: begin
          rsp_valid_d       = 1'b1;
          rsp_d.seq_out     = cur_q.seq;
          rsp_d.last_result = 1'b1;
          state_d           = S_IDLE;
          if (vld && (rdat.seq != cur_q.seq)) begin
            rsp_d.outcome = OC_COLLISION;
          end else begin
            we                = 1'b1;
            wdata.seq         = cur_q.seq;
            wdata.status      = cur_q.status;
            wdata.rel         = cur_q.rel;
            valid_d[rd_idx_q] = 1'b1;
            rsp_d.outcome     = vld ? OC_REPLACED : OC_OK;
          end
        end
        OP_QUERY: begin
          rsp_valid_d       = 1'b1;
          rsp_d.outcome     = OC_OK;
          rsp_d.found       = hit && rdat.rel && (rdat.status == ST_ACKED);
          rsp_d.last_result = 1'b1;
          state_d           = S_IDLE;
        end
        OP_REQ: begin
          if (rd_base_q) begin
            base_hit_d = hit;
            base_hit_f = hit;
          end
          if ((rd_base_q || rd_use_q) && hit) begin
            we           = 1'b1;
            wdata.status = ST_REQUESTED;
          end
          if (rd_use_q && !hit) begin
            miss_d = miss_q + 6'd1;
          end
          if (rd_last_q) begin
            rsp_valid_d         = 1'b1;
            rsp_d.outcome       = base_hit_f ? OC_OK : OC_BASE_MISS;
            rsp_d.missing_count = miss_d;
            rsp_d.last_result   = 1'b1;
            state_d             = S_IDLE;
          end
        end
        OP_ACK: begin
          if (vld && (rdat.seq <= cur_q.seq)) begin
            we           = 1'b1;
            wdata.status = ST_ACKED;
          end
          if (rd_last_q) begin
            rsp_valid_d       = 1'b1;
            rsp_d.outcome     = OC_OK;
            rsp_d.last_result = 1'b1;
            state_d           = S_IDLE;
          end
        end
        OP_NEXT, OP_LIST: begin
          if (cand && (!best_vld_q || (rdat.seq < best_q))) begin
            best_vld_d = 1'b1;
            best_d     = rdat.seq;
          end
          if (rd_last_q) begin
            if (cur_q.op == OP_NEXT) begin
              rsp_valid_d       = 1'b1;
              rsp_d.last_result = 1'b1;
              rsp_d.outcome     = best_vld_d ? OC_OK : OC_NONE;
              rsp_d.found       = best_vld_d;
              rsp_d.seq_out     = best_vld_d ? best_d : '0;
              state_d           = S_IDLE;
            end else if (best_vld_d) begin
              // hold the newest hit back until we know whether it is the last
              if (have_q) begin
                rsp_valid_d   = 1'b1;
                rsp_d.outcome = OC_OK;
                rsp_d.found   = 1'b1;
                rsp_d.seq_out = prev_q;
              end
              have_d = 1'b1;
              prev_d = best_d;
              nres_d = nres_q + 6'd1;
              if (nres_q == 6'(MAX_RES - 1)) begin
                state_d = S_FLUSH;
              end else begin
                iss_d      = '0;
                best_vld_d = 1'b0;
              end
            end else begin
              rsp_valid_d       = 1'b1;
              rsp_d.last_result = 1'b1;
              rsp_d.outcome     = have_q ? OC_OK : OC_NONE;
              rsp_d.found       = have_q;
              rsp_d.seq_out     = have_q ? prev_q : '0;
              state_d           = S_IDLE;
            end
          end
        end
        default: state_d = S_IDLE;
      endcase
    end

    if (state_q == S_FLUSH) begin
      rsp_valid_d       = 1'b1;
      rsp_d.outcome     = OC_OK;
      rsp_d.found       = 1'b1;
      rsp_d.seq_out     = prev_q;
      rsp_d.last_result = 1'b1;
      state_d           = S_IDLE;
    end
  end

  // slot store, read data registered, bypass for a write to the address being read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[rd_idx_q] <= wdata;
    end
    mem_q      <= mem[raddr];
    byp_q      <= we && (rd_idx_q == raddr);
    byp_data_q <= wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
      iss_q       <= '0;
      total_q     <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      rd_vld_q    <= rd_vld_d;
      rsp_valid_q <= rsp_valid_d;
      iss_q       <= iss_d;
      total_q     <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    addr_q     <= addr_d;
    key_q      <= key_d;
    bmp_q      <= bmp_d;
    rd_idx_q   <= rd_idx_d;
    rd_key_q   <= rd_key_d;
    rd_base_q  <= rd_base_d;
    rd_use_q   <= rd_use_d;
    rd_last_q  <= rd_last_d;
    base_hit_q <= base_hit_d;
    miss_q     <= miss_d;
    nres_q     <= nres_d;
    best_vld_q <= best_vld_d;
    best_q     <= best_d;
    have_q     <= have_d;
    prev_q     <= prev_d;
    rsp_q      <= rsp_d;
  end

endmodule

`default_nettype wire

// ----- src/reliable_writer_change_status_table.sv -----
// channel       | signals                 | transfer
// command in    | start, busy, cmd_i      | start high while busy low
// result out    | rsp_valid_o, rsp_o      | strobe for one cycle, always taken
//
// the back runs each popped transaction as a run of slot reads: add and query read
// one slot, request set len+1 slots, ack and next-with-status all WINDOW slots; list
// runs one WINDOW-slot scan per reported entry plus a closing empty scan, or a
// flush state after the 32nd entry (one slot read and one slot write per cycle)
// the front holds busy after each accepted transaction until it pushes it; for a
// non-power-of-two WINDOW it first reduces the slot index four bits a cycle. It
// overlaps the back through a 2-entry queue
// reset clears the slot valid bits at once, no clearing pass
// busy stays high while the front holds a command the queue cannot take
// the receiver cannot stall results
`default_nettype none

module reliable_writer_change_status_table #(
  parameter int unsigned WINDOW      = 32,
  parameter int unsigned BITMAP_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  rwcst_pkg::cmd_t cmd_i,
  output logic            rsp_valid_o,
  output rwcst_pkg::rsp_t rsp_o
);
  import rwcst_pkg::*;

  // front to queue
  logic  push, full;
  work_t push_work;

  // queue to back
  logic  pop, empty;
  work_t pop_work;

  // front: takes a transaction, works out its slot and clamps the bitmap length
  rwcst_front #(
    .WINDOW      (WINDOW),
    .BITMAP_BITS (BITMAP_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .push_o (push),
    .work_o (push_work),
    .full_i (full)
  );

  // short queue lets the front take the next command while the back scans
  rwcst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_work),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_work),
    .empty_o (empty)
  );

  // back: owns the slot store and runs the lookups, scans and status updates
  rwcst_back #(
    .WINDOW      (WINDOW),
    .BITMAP_BITS (BITMAP_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .work_i      (pop_work),
    .pop_o       (pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
